// ----- rtl/core/clre_pkg.sv -----
// ----------------------------------------------------------------------------
// clre_pkg
// Types, constants and frame helpers for the character LCD refresh engine.
// ----------------------------------------------------------------------------
`default_nettype none

package clre_pkg;

  localparam int COLUMNS = 16;
  localparam int ROWS    = 2;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int AW      = $clog2(CELLS);
  localparam int CW      = $clog2(COLUMNS);
  localparam int PTRW    = $clog2(2 * COLUMNS + 16);

  localparam int INIT_LEN = 9;

  localparam logic [7:0] CMD_ROW0 = 8'h80;
  localparam logic [7:0] CMD_ROW1 = 8'hC0;
  localparam logic [7:0] SPACE    = 8'h20;

  typedef logic [PTRW-1:0] ptr_t;
  typedef logic [AW-1:0]   addr_t;
  typedef logic [CW-1:0]   col_t;

  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_REFRESH = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_CMD,
    S_RD,
    S_DATA
  } state_e;

  function automatic logic [31:0] make_frame(logic [7:0] value, logic is_data);
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] rs;
    hi = {value[7:4], 4'h0};
    lo = {value[3:0], 4'h0};
    rs = {7'd0, is_data};
    return {lo | 8'h08 | rs, lo | 8'h0C | rs, hi | 8'h08 | rs, hi | 8'h0C | rs};
  endfunction

  function automatic logic [7:0] setup_cmd(logic [3:0] idx);
    logic [7:0] cmd;
    case (idx)
      4'd0, 4'd1, 4'd2: cmd = 8'h30;
      4'd3:             cmd = 8'h20;
      4'd4:             cmd = 8'h28;
      4'd5:             cmd = 8'h08;
      4'd6:             cmd = 8'h01;
      4'd7:             cmd = 8'h06;
      default:          cmd = 8'h0C;
    endcase
    return cmd;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/char_lcd_refresh_over_i2c_expander.sv -----
// ----------------------------------------------------------------------------
// char_lcd_refresh_over_i2c_expander
// HD44780 4-bit refresh engine emitting 32-bit expander frames.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one command word: init, write
// character, clear buffer or refresh. Output channel (out_valid_o /
// out_stall_i) returns result words, last_o marking the final one.
// Write, clear and refresh-before-init: one result, registered one cycle after
// acceptance. Init: nine command frames, one per cycle when the output is free.
// Refresh: per row a cursor command, then one data frame per column (buffer
// RAM read, then frame build). The block works on one command at a time; a
// write or clear is taken back to back while the output register is free.
// Init and clear empty the buffer at once: a per-cell written bit marks RAM
// entries, and unwritten cells read as the last fill value (zero or space).
// Reset clears the written bits, the pointer and the ready flag, and drops
// any pending output. A stalled receiver holds the output word and the input
// side stalls until that word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_refresh_over_i2c_expander (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic        row_i,
  input  wire logic [3:0]  col_i,
  input  wire logic [7:0]  character_i,
  input  wire logic        start_req_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      frame_o,
  output logic             frame_valid_o,
  output logic             last_o,
  output logic             status_o
);

  clre_pkg::state_e state_q, state_d;
  logic [3:0]              idx_q, idx_d;
  logic                    row_q, row_d;
  clre_pkg::col_t          col_q, col_d;
  clre_pkg::addr_t         addr_q, addr_d;
  clre_pkg::ptr_t          wp_q, wp_d;
  logic                    ready_q, ready_d;
  logic [7:0]              fill_q, fill_d;
  logic [clre_pkg::CELLS-1:0] vld_q, vld_d;

  logic [7:0] mem [clre_pkg::CELLS];
  logic [7:0] rdata_q;
  logic       rd_vld_q;
  logic       mem_we, mem_re;
  clre_pkg::addr_t mem_waddr;

  logic        out_valid_q;
  logic [31:0] frame_q;
  logic        fvalid_q, last_q, status_q;
  logic        out_load;
  logic [31:0] frame_d;
  logic        fvalid_d, last_d, status_d;
  logic        out_free, accept;
  clre_pkg::ptr_t ptr;
  logic [7:0]  rd_char;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != clre_pkg::S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign ptr        = start_req_i ?
                      clre_pkg::ptr_t'(row_i) * clre_pkg::ptr_t'(clre_pkg::COLUMNS) +
                      clre_pkg::ptr_t'(col_i) : wp_q;
  assign mem_waddr  = ptr[clre_pkg::AW-1:0];
  assign rd_char    = rd_vld_q ? rdata_q : fill_q;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    row_d    = row_q;
    col_d    = col_q;
    addr_d   = addr_q;
    wp_d     = wp_q;
    ready_d  = ready_q;
    fill_d   = fill_q;
    vld_d    = vld_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    out_load = 1'b0;
    frame_d  = '0;
    fvalid_d = 1'b0;
    last_d   = 1'b1;
    status_d = 1'b0;
    case (state_q)
      clre_pkg::S_IDLE: begin
        if (accept) begin
          case (operation_i)
            clre_pkg::OP_INIT: begin
              vld_d   = '0;
              fill_d  = 8'h00;
              ready_d = 1'b1;
              idx_d   = 4'd0;
              state_d = clre_pkg::S_INIT;
            end
            clre_pkg::OP_WRITE: begin
              out_load = 1'b1;
              if (ptr < clre_pkg::ptr_t'(clre_pkg::CELLS)) begin
                mem_we           = 1'b1;
                vld_d[mem_waddr] = 1'b1;
                wp_d             = ptr + 1'b1;
              end else begin
                wp_d = clre_pkg::ptr_t'(clre_pkg::CELLS);
              end
            end
            clre_pkg::OP_CLEAR: begin
              out_load = 1'b1;
              vld_d    = '0;
              fill_d   = clre_pkg::SPACE;
            end
            default: begin
              if (!ready_q) begin
                out_load = 1'b1;
                status_d = 1'b1;
              end else begin
                row_d   = 1'b0;
                col_d   = '0;
                addr_d  = '0;
                state_d = clre_pkg::S_CMD;
              end
            end
          endcase
        end
      end
      clre_pkg::S_INIT: begin
        frame_d  = clre_pkg::make_frame(clre_pkg::setup_cmd(idx_q), 1'b0);
        fvalid_d = 1'b1;
        last_d   = (idx_q == 4'(clre_pkg::INIT_LEN - 1));
        if (out_free) begin
          out_load = 1'b1;
          idx_d    = idx_q + 4'd1;
          if (last_d) begin
            state_d = clre_pkg::S_IDLE;
          end
        end
      end
      clre_pkg::S_CMD: begin
        frame_d  = clre_pkg::make_frame(row_q ? clre_pkg::CMD_ROW1 : clre_pkg::CMD_ROW0,
                                        1'b0);
        fvalid_d = 1'b1;
        last_d   = 1'b0;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = clre_pkg::S_RD;
        end
      end
      clre_pkg::S_RD: begin
        mem_re  = 1'b1;
        state_d = clre_pkg::S_DATA;
      end
      clre_pkg::S_DATA: begin
        frame_d  = clre_pkg::make_frame(rd_char, 1'b1);
        fvalid_d = 1'b1;
        last_d   = (addr_q == clre_pkg::addr_t'(clre_pkg::CELLS - 1));
        if (out_free) begin
          out_load = 1'b1;
          addr_d   = addr_q + 1'b1;
          if (col_q == clre_pkg::col_t'(clre_pkg::COLUMNS - 1)) begin
            col_d = '0;
            if (last_d) begin
              state_d = clre_pkg::S_IDLE;
            end else begin
              row_d   = 1'b1;
              state_d = clre_pkg::S_CMD;
            end
          end else begin
            col_d   = col_q + 1'b1;
            state_d = clre_pkg::S_RD;
          end
        end
      end
      default: begin
        state_d = clre_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= clre_pkg::S_IDLE;
      idx_q       <= '0;
      row_q       <= 1'b0;
      col_q       <= '0;
      addr_q      <= '0;
      wp_q        <= '0;
      ready_q     <= 1'b0;
      fill_q      <= 8'h00;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      row_q   <= row_d;
      col_q   <= col_d;
      addr_q  <= addr_d;
      wp_q    <= wp_d;
      ready_q <= ready_d;
      fill_q  <= fill_d;
      vld_q   <= vld_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      frame_q  <= frame_d;
      fvalid_q <= fvalid_d;
      last_q   <= last_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= character_i;
    end
    if (mem_re) begin
      rdata_q  <= mem[addr_q];
      rd_vld_q <= vld_q[addr_q];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_o       = frame_q;
  assign frame_valid_o = fvalid_q;
  assign last_o        = last_q;
  assign status_o      = status_q;

endmodule

`default_nettype wire

// ----- rtl/core/clre_chk.sv -----
// ----------------------------------------------------------------------------
// clre_chk
// Port-level checks for the character LCD refresh engine.
// ----------------------------------------------------------------------------
`default_nettype none

module clre_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [1:0]  operation_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] frame_o,
  input wire logic        frame_valid_o,
  input wire logic        last_o,
  input wire logic        status_o
);

  // a held output word blocks new commands
  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted while output word held");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(frame_o) && $stable(last_o))
    else $error("stalled output word changed");

  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_valid_o |-> frame_o == 32'd0 && last_o)
    else $error("frameless word not empty or not last");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> !frame_valid_o && last_o)
    else $error("error status on a frame");

  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (operation_i == clre_pkg::OP_WRITE ||
                                  operation_i == clre_pkg::OP_CLEAR)
    |=> out_valid_o && last_o && !frame_valid_o && !status_o)
    else $error("write or clear result missing");

endmodule

bind char_lcd_refresh_over_i2c_expander clre_chk u_clre_chk (.*);

`default_nettype wire

// ----- tb/sv/char_lcd_refresh_over_i2c_expander_test.sv -----
// ----------------------------------------------------------------------------
// char_lcd_refresh_over_i2c_expander_test
// Self-checking bench for the character LCD refresh engine. A driver feeds
// command words from a queue with random gaps. A monitor models the character
// buffer, write pointer and ready flag, queues the expander frames that each
// accepted word should produce, and compares them in order against the output
// channel while the receiver stalls at random, including one long hold-off.
// ----------------------------------------------------------------------------
module char_lcd_refresh_over_i2c_expander_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [8*clre_pkg::INIT_LEN-1:0] SETUP_SEQ = 72'h30_30_30_20_28_08_01_06_0C;

  typedef struct {
    clre_pkg::op_e op;
    logic       row;
    logic [3:0] col;
    logic [7:0] chr;
    logic       start;
    int         gap;
    bit         pause;
  } lcd_cmd_t;

  typedef struct {
    logic [31:0] frame;
    logic        fvalid;
    logic        last;
    logic        status;
  } lcd_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = 2'd0;
  logic        row_i = 1'b0;
  logic [3:0]  col_i = 4'd0;
  logic [7:0]  character_i = 8'd0;
  logic        start_req_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] frame_o;
  logic        frame_valid_o;
  logic        last_o;
  logic        status_o;

  lcd_cmd_t  cmd_q[$];
  lcd_word_t frame_q[$];

  logic [7:0] lcd_cells [clre_pkg::CELLS];
  int         wr_ptr;
  bit         lcd_ready;

  bit in_fire = 1'b0;
  int words_in = 0;
  int err_cnt = 0;
  int cycles = 0;
  int gap_left = 0;
  int hold_left = 0;
  int stall_left = 0;
  int quiet_left = 0;
  bit held_once = 1'b0;
  int stall_roll;
  int quiet_items = 0;

  char_lcd_refresh_over_i2c_expander DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .character_i  (character_i),
    .start_req_i  (start_req_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_o      (frame_o),
    .frame_valid_o(frame_valid_o),
    .last_o       (last_o),
    .status_o     (status_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [31:0] lcd_frame(logic [7:0] value, logic rs);
    logic [7:0] hb;
    logic [7:0] lb;
    logic [7:0] ctl;
    hb  = value & 8'hF0;
    lb  = {value[3:0], 4'h0};
    ctl = rs ? 8'h0D : 8'h0C;
    return {lb | (ctl & 8'hFB), lb | ctl, hb | (ctl & 8'hFB), hb | ctl};
  endfunction

  function automatic void push_cmd(clre_pkg::op_e op, logic row, logic [3:0] col,
                                   logic [7:0] chr, logic start);
    lcd_cmd_t c;
    int roll;
    roll = $urandom_range(0, 99);
    c.op = op;
    c.row = row;
    c.col = col;
    c.chr = chr;
    c.start = start;
    c.pause = 1'b0;
    if (quiet_items > 0) begin
      quiet_items = quiet_items - 1;
      c.gap = 0;
    end else if (roll < 5) begin
      quiet_items = 15;
      c.gap = 0;
    end else if (roll < 60) begin
      c.gap = 0;
    end else if (roll < 90) begin
      c.gap = $urandom_range(1, 3);
    end else if (roll < 97) begin
      c.gap = $urandom_range(4, 10);
    end else begin
      c.gap = $urandom_range(20, 60);
    end
    cmd_q.push_back(c);
  endfunction

  function automatic void push_pause();
    lcd_cmd_t c;
    c.op = clre_pkg::OP_CLEAR;
    c.row = 1'b0;
    c.col = 4'd0;
    c.chr = 8'd0;
    c.start = 1'b0;
    c.gap = 0;
    c.pause = 1'b1;
    cmd_q.push_back(c);
  endfunction

  task automatic predict_lcd(lcd_cmd_t c);
    lcd_word_t w;
    int i;
    int r;
    int k;
    w.frame  = '0;
    w.fvalid = 1'b0;
    w.last   = 1'b1;
    w.status = 1'b0;
    case (c.op)
      clre_pkg::OP_INIT: begin
        for (i = 0; i < clre_pkg::CELLS; i++) lcd_cells[i] = 8'h00;
        for (i = 0; i < clre_pkg::INIT_LEN; i++) begin
          w.frame  = lcd_frame(SETUP_SEQ[8*(clre_pkg::INIT_LEN-1-i) +: 8], 1'b0);
          w.fvalid = 1'b1;
          w.last   = (i == clre_pkg::INIT_LEN - 1);
          frame_q.push_back(w);
        end
        lcd_ready = 1'b1;
      end
      clre_pkg::OP_WRITE: begin
        if (c.start) wr_ptr = int'(c.row) * clre_pkg::COLUMNS + int'(c.col);
        if (wr_ptr < clre_pkg::CELLS) begin
          lcd_cells[wr_ptr] = c.chr;
          wr_ptr = wr_ptr + 1;
        end else begin
          wr_ptr = clre_pkg::CELLS;
        end
        frame_q.push_back(w);
      end
      clre_pkg::OP_CLEAR: begin
        for (i = 0; i < clre_pkg::CELLS; i++) lcd_cells[i] = clre_pkg::SPACE;
        frame_q.push_back(w);
      end
      default: begin
        if (!lcd_ready) begin
          w.status = 1'b1;
          frame_q.push_back(w);
        end else begin
          w.fvalid = 1'b1;
          for (r = 0; r < clre_pkg::ROWS; r++) begin
            w.frame = lcd_frame(r == 0 ? clre_pkg::CMD_ROW0 : clre_pkg::CMD_ROW1, 1'b0);
            w.last  = 1'b0;
            frame_q.push_back(w);
            for (k = 0; k < clre_pkg::COLUMNS; k++) begin
              w.frame = lcd_frame(lcd_cells[r*clre_pkg::COLUMNS + k], 1'b1);
              w.last  = (r == clre_pkg::ROWS - 1) && (k == clre_pkg::COLUMNS - 1);
              frame_q.push_back(w);
            end
          end
        end
      end
    endcase
  endtask

  task automatic check_word();
    lcd_word_t want;
    if (frame_q.size() == 0) begin
      err_cnt++;
      $display("%0t unexpected word: expected none, got frame %h valid %b last %b status %b",
               $time, frame_o, frame_valid_o, last_o, status_o);
    end else begin
      want = frame_q.pop_front();
      if ({frame_o, frame_valid_o, last_o, status_o} !==
          {want.frame, want.fvalid, want.last, want.status}) begin
        err_cnt++;
        $display({"%0t mismatch: expected frame %h valid %b last %b status %b,",
                  " got frame %h valid %b last %b status %b"},
                 $time, want.frame, want.fvalid, want.last, want.status,
                 frame_o, frame_valid_o, last_o, status_o);
      end
    end
  endtask

  // monitor: results first, they belong to older words
  always @(posedge clk_i) begin
    lcd_cmd_t seen;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) check_word();
      if (in_valid_i && !in_stall_o) begin
        seen.op    = clre_pkg::op_e'(operation_i);
        seen.row   = row_i;
        seen.col   = col_i;
        seen.chr   = character_i;
        seen.start = start_req_i;
        seen.gap   = 0;
        seen.pause = 1'b0;
        predict_lcd(seen);
        words_in++;
      end
    end
  end

  always @(negedge clk_i) begin
    lcd_cmd_t cur;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (cmd_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (cmd_q[0].pause) begin
        in_valid_i <= 1'b0;
        if (frame_q.size() == 0) void'(cmd_q.pop_front());
      end else begin
        cur = cmd_q.pop_front();
        in_valid_i  <= 1'b1;
        operation_i <= cur.op;
        row_i       <= cur.row;
        col_i       <= cur.col;
        character_i <= cur.chr;
        start_req_i <= cur.start;
        gap_left    <= cur.gap;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!held_once && words_in >= 60) begin
      held_once <= 1'b1;
      hold_left <= 300;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (quiet_left > 0) begin
      quiet_left <= quiet_left - 1;
      out_stall_i <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 4) begin
        quiet_left <= 80;
        out_stall_i <= 1'b0;
      end else if (stall_roll < 70) begin
        out_stall_i <= 1'b0;
      end else if (stall_roll < 95) begin
        stall_left <= $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        stall_left <= $urandom_range(8, 40);
        out_stall_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("[char_lcd_refresh_over_i2c_expander] ERROR");
      $finish;
    end
  end

  initial begin
    int n_rand;
    int pick;
    int len;
    int k;
    bit paused_mid;
    for (k = 0; k < clre_pkg::CELLS; k++) lcd_cells[k] = 8'h00;
    wr_ptr = 0;
    lcd_ready = 1'b0;

    // refresh before init, writes before init, drop at the end of the buffer
    push_cmd(clre_pkg::OP_REFRESH, 1'b0, 4'd0, 8'h00, 1'b0);
    push_cmd(clre_pkg::OP_WRITE, 1'b1, 4'd15, 8'hFF, 1'b1);
    push_cmd(clre_pkg::OP_WRITE, 1'b0, 4'd0, 8'h01, 1'b0);
    push_cmd(clre_pkg::OP_INIT, 1'b0, 4'd0, 8'h00, 1'b0);
    push_cmd(clre_pkg::OP_WRITE, 1'b0, 4'd0, 8'h7E, 1'b0);
    push_cmd(clre_pkg::OP_REFRESH, 1'b0, 4'd0, 8'h00, 1'b0);
    push_cmd(clre_pkg::OP_WRITE, 1'b0, 4'd0, 8'h00, 1'b1);
    push_cmd(clre_pkg::OP_WRITE, 1'b0, 4'd0, 8'h80, 1'b0);
    // string running from row 0 into row 1
    push_cmd(clre_pkg::OP_WRITE, 1'b0, 4'd14, 8'h7F, 1'b1);
    push_cmd(clre_pkg::OP_WRITE, 1'b0, 4'd0, 8'h55, 1'b0);
    push_cmd(clre_pkg::OP_WRITE, 1'b0, 4'd0, 8'hAA, 1'b0);
    push_cmd(clre_pkg::OP_REFRESH, 1'b0, 4'd0, 8'h00, 1'b0);
    push_cmd(clre_pkg::OP_CLEAR, 1'b0, 4'd0, 8'h00, 1'b0);
    push_cmd(clre_pkg::OP_WRITE, 1'b1, 4'd7, 8'hA5, 1'b1);
    push_cmd(clre_pkg::OP_WRITE, 1'b0, 4'd0, 8'h5A, 1'b0);
    push_cmd(clre_pkg::OP_REFRESH, 1'b0, 4'd0, 8'h00, 1'b0);
    push_pause();
    // init keeps the pointer
    push_cmd(clre_pkg::OP_INIT, 1'b0, 4'd0, 8'h00, 1'b0);
    push_cmd(clre_pkg::OP_WRITE, 1'b0, 4'd0, 8'h0F, 1'b0);
    push_cmd(clre_pkg::OP_WRITE, 1'b0, 4'd0, 8'hF0, 1'b0);
    push_cmd(clre_pkg::OP_REFRESH, 1'b0, 4'd0, 8'h00, 1'b0);
    push_cmd(clre_pkg::OP_CLEAR, 1'b0, 4'd0, 8'h00, 1'b0);
    push_cmd(clre_pkg::OP_REFRESH, 1'b0, 4'd0, 8'h00, 1'b0);
    push_pause();

    n_rand = 0;
    paused_mid = 1'b0;
    while (n_rand < 108) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = $urandom_range(1, 12);
        push_cmd(clre_pkg::OP_WRITE, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                 8'($urandom), 1'b1);
        for (k = 1; k < len; k++)
          push_cmd(clre_pkg::OP_WRITE, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                   8'($urandom), 1'b0);
        n_rand += len;
      end else if (pick < 75) begin
        push_cmd(clre_pkg::OP_REFRESH, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                 8'($urandom), 1'($urandom_range(0, 1)));
        n_rand++;
      end else if (pick < 82) begin
        push_cmd(clre_pkg::OP_CLEAR, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                 8'($urandom), 1'($urandom_range(0, 1)));
        n_rand++;
      end else if (pick < 87) begin
        push_cmd(clre_pkg::OP_INIT, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                 8'($urandom), 1'($urandom_range(0, 1)));
        n_rand++;
      end else begin
        push_cmd(clre_pkg::op_e'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)),
                 4'($urandom_range(0, 15)), 8'($urandom), 1'($urandom_range(0, 1)));
        n_rand++;
      end
      if (!paused_mid && n_rand >= 80) begin
        paused_mid = 1'b1;
        push_pause();
      end
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[char_lcd_refresh_over_i2c_expander] OK");
    end else begin
      $display("[char_lcd_refresh_over_i2c_expander] ERROR");
    end
    $finish;
  end

endmodule
